### src/operator_console_line_controller_defines.svh
// Assertion macros shared by the checker of the console line controller.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef OPERATOR_CONSOLE_LINE_CONTROLLER_DEFINES_SVH
`define OPERATOR_CONSOLE_LINE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OCL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ocl_pkg.sv
// Package of the operator console line controller: payload types, codes
// and the job record passed from the control unit to the result sequencer.
// No dependencies.
package ocl_pkg;

  localparam int unsigned LINE_CHARS_DEF = 81;

  localparam int unsigned WORD_W    = 36;
  localparam int unsigned CHAR_W    = 9;
  localparam int unsigned KEY_W     = 8;
  localparam int unsigned CHARS_PER_WORD = 4;
  localparam int unsigned READ_SHIFT = 27;

  // Item kinds on the input channel.
  localparam logic [1:0] OP_CMD  = 2'd0;
  localparam logic [1:0] OP_XFER = 2'd1;
  localparam logic [1:0] OP_KEY  = 2'd2;

  // Channel command codes.
  localparam logic [5:0] CMD_STATUS = 6'o00;
  localparam logic [5:0] CMD_READ   = 6'o23;
  localparam logic [5:0] CMD_WRITE  = 6'o33;
  localparam logic [5:0] CMD_RESET  = 6'o40;
  localparam logic [5:0] CMD_ALERT  = 6'o51;

  // Result kinds.
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_BELL   = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_LENGTH  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // Keyboard codes with a special meaning.
  localparam logic [7:0] KEY_DEL = 8'o177;
  localparam logic [7:0] KEY_BS  = 8'o010;
  localparam logic [7:0] KEY_FF  = 8'o014;
  localparam logic [7:0] KEY_CR  = 8'o015;

  // Terminal characters that are dropped in write mode besides zero.
  localparam logic [8:0] CHAR_RUBOUT = 9'o177;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [5:0]        command_code;
    logic [5:0]        unit_code;
    logic [WORD_W-1:0] write_word;
    logic [KEY_W-1:0]  key_char;
  } in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        status;
    logic              line_done;
    logic [WORD_W-1:0] read_word;
    logic [CHAR_W-1:0] out_char;
    logic              last;
  } out_t;

  // Work left for one transaction: an optional bell, the terminal characters
  // still to send (bit 0 is the character in the top nine bits), and the
  // closing status result, which may carry the character read from the line.
  typedef struct packed {
    logic                      bell;
    logic [CHARS_PER_WORD-1:0] char_mask;
    logic [WORD_W-1:0]         chars;
    logic [1:0]                status;
    logic                      line_done;
    logic                      use_char;
  } job_t;

endpackage

### src/operator_console_line_controller.sv
// Operator console line controller. Each cycle that the sequencer is free it
// takes one transaction: a channel command, a data transfer or a keystroke.
// A keystroke gives no result. Any other transaction gives one to five
// results (an alert two, a write transfer up to five), issued one per cycle
// through an output register while the output is not stalled; the next
// transaction is taken in the cycle its last result is issued. The line
// characters live in one synchronous memory of LINE_CHARS entries whose read
// data arrives in the cycle after the read transfer is taken; the line needs
// no clearing after reset.
module operator_console_line_controller #(
  parameter int unsigned LINE_CHARS = ocl_pkg::LINE_CHARS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ocl_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ocl_pkg::out_t out_data_o
);

  localparam int unsigned ADDR_W = $clog2(LINE_CHARS);

  logic              accept;
  logic              job_valid;
  ocl_pkg::job_t     job;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;

  assign accept = in_valid_i && in_ready_o;

  ocl_ctrl #(
    .LINE_CHARS (LINE_CHARS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr)
  );

  ocl_line_mem #(
    .DEPTH (LINE_CHARS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ocl_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .job_valid_i (job_valid),
    .job_i       (job),
    .rdata_i     (mem_rdata),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_data_o)
  );

endmodule

### src/ocl_line_mem.sv
// Line buffer of the console controller: one synchronous memory with one
// write port and one registered read port. Depends on nothing.
module ocl_line_mem #(
  parameter int unsigned DEPTH  = 81,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/ocl_ctrl.sv
// Control unit of the console controller: holds mode, line indexes and the
// end-of-line flag, decodes each transaction and drives the line memory.
// Depends on ocl_pkg.
module ocl_ctrl #(
  parameter int unsigned LINE_CHARS = ocl_pkg::LINE_CHARS_DEF,
  parameter int unsigned IDX_W      = $clog2(LINE_CHARS + 1),
  parameter int unsigned ADDR_W     = $clog2(LINE_CHARS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  ocl_pkg::in_t      in_data_i,
  output logic              job_valid_o,
  output ocl_pkg::job_t     job_o,
  output logic              mem_we_o,
  output logic [ADDR_W-1:0] mem_waddr_o,
  output logic [7:0]        mem_wdata_o,
  output logic              mem_re_o,
  output logic [ADDR_W-1:0] mem_raddr_o
);

  ocl_pkg::mode_e   mode_q, mode_d;
  logic [IDX_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] read_q, read_d;
  logic [IDX_W-1:0] read_next;
  logic             eol_q, eol_d;
  logic             full;
  logic [ocl_pkg::CHAR_W-1:0] wchar [ocl_pkg::CHARS_PER_WORD];

  assign full = (fill_q >= IDX_W'(LINE_CHARS));

  always_comb begin
    for (int i = 0; i < int'(ocl_pkg::CHARS_PER_WORD); i++) begin
      wchar[i] = in_data_i.write_word[ocl_pkg::WORD_W-1-ocl_pkg::CHAR_W*i -: ocl_pkg::CHAR_W];
    end
  end

  always_comb begin
    mode_d      = mode_q;
    fill_d      = fill_q;
    read_d      = read_q;
    eol_d       = eol_q;
    read_next   = read_q;
    job_valid_o = 1'b0;
    job_o       = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = fill_q[ADDR_W-1:0];
    mem_wdata_o = in_data_i.key_char;
    mem_re_o    = 1'b0;
    mem_raddr_o = read_q[ADDR_W-1:0];

    if (accept_i) begin
      case (in_data_i.op)
        ocl_pkg::OP_CMD: begin
          job_valid_o = 1'b1;
          if (in_data_i.unit_code != 6'd0) begin
            job_o.status    = ocl_pkg::ST_REJECT;
            job_o.line_done = 1'b1;
          end else begin
            case (in_data_i.command_code)
              ocl_pkg::CMD_STATUS: ;
              ocl_pkg::CMD_READ: begin
                mode_d = ocl_pkg::MODE_READ;
                fill_d = '0;
                read_d = '0;
                eol_d  = 1'b0;
              end
              ocl_pkg::CMD_WRITE: mode_d = ocl_pkg::MODE_WRITE;
              ocl_pkg::CMD_RESET: mode_d = ocl_pkg::MODE_NONE;
              ocl_pkg::CMD_ALERT: job_o.bell = 1'b1;
              default: begin
                job_o.status    = ocl_pkg::ST_REJECT;
                job_o.line_done = 1'b1;
              end
            endcase
          end
        end

        ocl_pkg::OP_XFER: begin
          job_valid_o = 1'b1;
          case (mode_q)
            ocl_pkg::MODE_READ: begin
              if (!eol_q) begin
                job_o.status    = full ? ocl_pkg::ST_LENGTH : ocl_pkg::ST_TIMEOUT;
                job_o.line_done = 1'b1;
              end else begin
                // Past the line the character reads as zero and nothing is fetched.
                if (read_q < fill_q) begin
                  job_o.use_char = 1'b1;
                  mem_re_o       = 1'b1;
                  read_next      = read_q + 1'b1;
                end
                if (read_next >= fill_q) begin
                  read_d          = '0;
                  fill_d          = '0;
                  job_o.line_done = 1'b1;
                end else begin
                  read_d = read_next;
                end
              end
            end
            ocl_pkg::MODE_WRITE: begin
              job_o.chars = in_data_i.write_word;
              for (int i = 0; i < int'(ocl_pkg::CHARS_PER_WORD); i++) begin
                job_o.char_mask[i] = (wchar[i] != '0) && (wchar[i] != ocl_pkg::CHAR_RUBOUT);
              end
            end
            default: begin
              job_o.status    = ocl_pkg::ST_REJECT;
              job_o.line_done = 1'b1;
            end
          endcase
        end

        ocl_pkg::OP_KEY: begin
          if (!full && !eol_q) begin
            case (in_data_i.key_char)
              ocl_pkg::KEY_DEL, ocl_pkg::KEY_BS: begin
                if (fill_q != '0) begin
                  fill_d = fill_q - 1'b1;
                end
              end
              ocl_pkg::KEY_FF: ;
              ocl_pkg::KEY_CR: eol_d = 1'b1;
              default: begin
                mem_we_o = 1'b1;
                fill_d   = fill_q + 1'b1;
              end
            endcase
          end
        end

        default: ;
      endcase
    end
  end

  // A key write and a line read never come from the same transaction, and a
  // read needs the end of line, so a write always lands before it is read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ocl_pkg::MODE_NONE;
      fill_q <= '0;
      read_q <= '0;
      eol_q  <= 1'b0;
    end else begin
      mode_q <= mode_d;
      fill_q <= fill_d;
      read_q <= read_d;
      eol_q  <= eol_d;
    end
  end

endmodule

### src/ocl_emit.sv
// Result sequencer of the console controller: holds the job of one
// transaction and issues its results, one per cycle while the output is not
// stalled, into an output register. Depends on ocl_pkg.
module ocl_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          job_valid_i,
  input  ocl_pkg::job_t job_i,
  input  logic [7:0]    rdata_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ocl_pkg::out_t out_o
);

  ocl_pkg::job_t job_q, job_d;
  logic          job_valid_q, job_valid_d;
  ocl_pkg::out_t out_q, res;
  logic          out_valid_q, out_valid_d;
  logic          load;
  logic          job_last;
  logic          found;
  logic [ocl_pkg::CHARS_PER_WORD-1:0] clr;

  assign load       = job_valid_q && (!out_valid_q || out_ready_i);
  assign job_last   = !job_q.bell && (job_q.char_mask == '0);
  assign in_ready_o = !job_valid_q || (load && job_last);

  always_comb begin
    res   = '0;
    found = 1'b0;
    clr   = '0;
    if (job_q.bell) begin
      res.kind = ocl_pkg::KIND_BELL;
    end else if (job_q.char_mask != '0) begin
      res.kind = ocl_pkg::KIND_CHAR;
      for (int i = 0; i < int'(ocl_pkg::CHARS_PER_WORD); i++) begin
        if (!found && job_q.char_mask[i]) begin
          found        = 1'b1;
          clr[i]       = 1'b1;
          res.out_char = job_q.chars[ocl_pkg::WORD_W-1-ocl_pkg::CHAR_W*i -: ocl_pkg::CHAR_W];
        end
      end
    end else begin
      res.kind      = ocl_pkg::KIND_STATUS;
      res.status    = job_q.status;
      res.line_done = job_q.line_done;
      res.last      = 1'b1;
      if (job_q.use_char) begin
        res.read_word = {1'b0, rdata_i, ocl_pkg::READ_SHIFT'(0)};
      end
    end
  end

  always_comb begin
    job_d       = job_q;
    job_valid_d = job_valid_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      if (job_q.bell) begin
        job_d.bell = 1'b0;
      end else begin
        job_d.char_mask = job_q.char_mask & ~clr;
      end
      if (job_last) begin
        job_valid_d = 1'b0;
      end
    end
    if (accept_i && job_valid_i) begin
      job_d       = job_i;
      job_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### src/ocl_chk.sv
// Port-level checker of the console line controller, bound to the top level.
// Depends on ocl_pkg and operator_console_line_controller_defines.svh.
`include "operator_console_line_controller_defines.svh"

module ocl_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input ocl_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input ocl_pkg::out_t out_data_o
);

  `OCL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  // A waiting input transaction keeps its payload until it is taken.
  `OCL_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o,
                   in_valid_i && $stable(in_data_i), "stalled input changed")
  `OCL_ASSERT_IMPL(a_char_clean, out_valid_o && out_data_o.kind == ocl_pkg::KIND_CHAR, !out_data_o.last && !out_data_o.line_done && out_data_o.status == ocl_pkg::ST_OK && out_data_o.read_word == '0, "terminal character result carries status fields")
  `OCL_ASSERT_IMPL(a_err_done, out_valid_o && out_data_o.kind == ocl_pkg::KIND_STATUS && out_data_o.status != ocl_pkg::ST_OK, out_data_o.line_done && out_data_o.read_word == '0, "error status without line done")
  `OCL_ASSERT_NEXT(a_bell_then_status, out_valid_o && out_ready_i && out_data_o.kind == ocl_pkg::KIND_BELL, out_valid_o && out_data_o.kind == ocl_pkg::KIND_STATUS && out_data_o.last, "bell not followed by its status")

endmodule

bind operator_console_line_controller ocl_chk u_ocl_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
